// ----- rtl/tts_pkg.sv -----
package tts_pkg;

   // Widths and sizes
   localparam int TOKEN_LIMIT = 4096;
   localparam int CFG_W       = 13;
   localparam int CNT_W       = $clog2(TOKEN_LIMIT + 1);
   localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
   localparam int REC_MAX     = 3;
   localparam int REC_IDX_W   = $clog2(REC_MAX);
   localparam int REC_CNT_W   = $clog2(REC_MAX + 1);
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);
   localparam int ESC_W       = 7;

   // Record kinds
   localparam logic KIND_CHAR   = 1'b0;
   localparam logic KIND_FINISH = 1'b1;

   // Token classes
   localparam logic [2:0] CLS_EOT     = 3'd0;
   localparam logic [2:0] CLS_IDENT   = 3'd1;
   localparam logic [2:0] CLS_STRING  = 3'd2;
   localparam logic [2:0] CLS_NUMBER  = 3'd3;
   localparam logic [2:0] CLS_BRACKET = 3'd4;
   localparam logic [2:0] CLS_ERROR   = 3'd5;

   // Error codes
   localparam logic [1:0] ERR_NONE     = 2'd0;
   localparam logic [1:0] ERR_TOO_LONG = 2'd1;
   localparam logic [1:0] ERR_UNTERM   = 2'd2;
   localparam logic [1:0] ERR_BAD_CHAR = 2'd3;

   // Characters of interest
   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_BS     = 8'h08;
   localparam logic [7:0] CH_BEL    = 8'h07;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UNDER  = 8'h5F;
   localparam logic [7:0] CH_LBRACE = 8'h7B;
   localparam logic [7:0] CH_RBRACE = 8'h7D;
   localparam logic [7:0] CH_UPPER_E = 8'h45;
   localparam logic [7:0] CH_LOWER_E = 8'h65;
   localparam logic [7:0] CH_LOWER_N = 8'h6E;
   localparam logic [7:0] CH_LOWER_R = 8'h72;
   localparam logic [7:0] CH_LOWER_T = 8'h74;
   localparam logic [7:0] CH_LOWER_B = 8'h62;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [ESC_W-1:0] ESC_MASK = 7'h7F;

   typedef enum logic [11:0] {
      MODE_IDLE    = 12'b0000_0000_0001,
      MODE_SLASH   = 12'b0000_0000_0010,
      MODE_COMMENT = 12'b0000_0000_0100,
      MODE_IDENT   = 12'b0000_0000_1000,
      MODE_STR     = 12'b0000_0001_0000,
      MODE_ESC     = 12'b0000_0010_0000,
      MODE_DEC     = 12'b0000_0100_0000,
      MODE_INT     = 12'b0000_1000_0000,
      MODE_FRAC    = 12'b0001_0000_0000,
      MODE_EXPS    = 12'b0010_0000_0000,
      MODE_EXPD    = 12'b0100_0000_0000,
      MODE_DISCARD = 12'b1000_0000_0000
   } mode_type;

   typedef struct packed {
      logic       kind;
      logic [2:0] cls;
      logic [7:0] value;
      logic [1:0] err;
   } rec_type;

   // All records caused by one text byte, oldest in slot 0.
   typedef struct packed {
      rec_type [REC_MAX-1:0]  recs;
      logic [REC_CNT_W-1:0]   count;
   } bundle_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
   endfunction

   function automatic logic is_bracket(input logic [7:0] c);
      return (c == CH_LBRACE) || (c == CH_RBRACE) || (c == CH_LPAREN) || (c == CH_RPAREN);
   endfunction

   function automatic rec_type mk_rec(input logic kind, input logic [2:0] cls,
                                      input logic [7:0] value, input logic [1:0] err);
      rec_type r;
      r.kind  = kind;
      r.cls   = cls;
      r.value = value;
      r.err   = err;
      return r;
   endfunction

endpackage

// ----- rtl/tts_front.sv -----
module tts_front import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_ch,
   input  logic             csr_valid,
   input  logic [CFG_W-1:0] csr_wdata,
   output logic             push_valid,
   input  logic             push_ready,
   output bundle_type       push_data
);

   mode_type             mode_ff, mode_in;
   logic                 quote_single_ff, quote_single_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [ESC_W-1:0]     esc_acc_ff, esc_acc_in;
   logic [CNT_W-1:0]     limit_ff, limit_in;
   logic [CMP_W-1:0]     cfg_ext;
   logic                 accept;
   bundle_type           bundle;

   function automatic void add(inout bundle_type b, input rec_type r);
      b.recs[b.count[REC_IDX_W-1:0]] = r;
      b.count = b.count + 1'b1;
   endfunction

   function automatic void fail(inout bundle_type b, inout mode_type m,
                                input logic [1:0] code, input logic [7:0] c);
      add(b, mk_rec(KIND_FINISH, CLS_ERROR, 8'h00, code));
      m = (c == CH_NUL) ? MODE_IDLE : MODE_DISCARD;
   endfunction

   function automatic void append(inout bundle_type b, inout mode_type m,
                                  inout logic [CNT_W-1:0] cnt, input logic [CNT_W-1:0] lim,
                                  input logic [2:0] cls, input logic [7:0] c);
      if (cnt >= lim) begin
         fail(b, m, ERR_TOO_LONG, c);
      end else begin
         add(b, mk_rec(KIND_CHAR, cls, c, ERR_NONE));
         cnt = cnt + 1'b1;
      end
   endfunction

   assign accept    = req_valid && req_ready;
   assign req_ready = push_ready;

   always_comb begin
      logic [7:0]  c;
      logic        do_idle;
      logic        do_body;
      logic [7:0]  term;
      logic [7:0]  esc_val;
      logic [10:0] acc_wide;
      c               = req_ch;
      do_idle         = 1'b0;
      do_body         = 1'b0;
      term            = CH_DQUOTE;
      esc_val         = c;
      acc_wide        = '0;
      mode_in         = mode_ff;
      quote_single_in = quote_single_ff;
      count_in        = count_ff;
      esc_acc_in      = esc_acc_ff;
      bundle          = '0;

      unique case (mode_ff)
         MODE_SLASH: begin
            if (c == CH_SLASH) begin
               mode_in = MODE_COMMENT;
            end else begin
               fail(bundle, mode_in, ERR_BAD_CHAR, c);
            end
         end
         MODE_COMMENT: begin
            if (c == CH_LF) begin
               mode_in = MODE_IDLE;
            end else if (c == CH_NUL) begin
               do_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_alpha(c) || is_digit(c) || (c == CH_UNDER)) begin
               append(bundle, mode_in, count_in, limit_ff, CLS_IDENT, c);
            end else begin
               add(bundle, mk_rec(KIND_FINISH, CLS_IDENT, 8'h00, ERR_NONE));
               do_idle = 1'b1;
            end
         end
         MODE_STR: begin
            do_body = 1'b1;
         end
         MODE_ESC: begin
            if (is_digit(c)) begin
               esc_acc_in = {3'b000, c[3:0]};
               mode_in    = MODE_DEC;
            end else if (c == CH_NUL) begin
               fail(bundle, mode_in, ERR_UNTERM, c);
            end else begin
               case (c)
                  CH_LOWER_N: esc_val = CH_LF;
                  CH_LOWER_R: esc_val = CH_CR;
                  CH_LOWER_T: esc_val = CH_TAB;
                  CH_LOWER_B: esc_val = CH_BS;
                  CH_LOWER_A: esc_val = CH_BEL;
                  default:    esc_val = c;
               endcase
               add(bundle, mk_rec(KIND_CHAR, CLS_STRING, esc_val, ERR_NONE));
               count_in = count_in + 1'b1;
               mode_in  = MODE_STR;
            end
         end
         MODE_DEC: begin
            if (is_digit(c)) begin
               acc_wide   = 11'(esc_acc_ff) * 11'd10 + 11'(c[3:0]);
               esc_acc_in = acc_wide[ESC_W-1:0] & ESC_MASK;
            end else begin
               add(bundle, mk_rec(KIND_CHAR, CLS_STRING, {1'b0, esc_acc_ff}, ERR_NONE));
               count_in   = count_in + 1'b1;
               esc_acc_in = '0;
               mode_in    = MODE_STR;
               do_body    = 1'b1;
            end
         end
         MODE_INT: begin
            if (is_digit(c)) begin
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else if (c == CH_DOT) begin
               mode_in = MODE_FRAC;
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else if ((c == CH_LOWER_E) || (c == CH_UPPER_E)) begin
               mode_in = MODE_EXPS;
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else begin
               add(bundle, mk_rec(KIND_FINISH, CLS_NUMBER, 8'h00, ERR_NONE));
               do_idle = 1'b1;
            end
         end
         MODE_FRAC: begin
            if (is_digit(c)) begin
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else if ((c == CH_LOWER_E) || (c == CH_UPPER_E)) begin
               mode_in = MODE_EXPS;
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else begin
               add(bundle, mk_rec(KIND_FINISH, CLS_NUMBER, 8'h00, ERR_NONE));
               do_idle = 1'b1;
            end
         end
         MODE_EXPS: begin
            if ((c == CH_PLUS) || (c == CH_MINUS) || is_digit(c)) begin
               mode_in = MODE_EXPD;
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else begin
               add(bundle, mk_rec(KIND_FINISH, CLS_NUMBER, 8'h00, ERR_NONE));
               do_idle = 1'b1;
            end
         end
         MODE_EXPD: begin
            if (is_digit(c)) begin
               append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
            end else begin
               add(bundle, mk_rec(KIND_FINISH, CLS_NUMBER, 8'h00, ERR_NONE));
               do_idle = 1'b1;
            end
         end
         MODE_DISCARD: begin
            if (c == CH_NUL) begin
               mode_in = MODE_IDLE;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      // String content, also reached from the end of a decimal escape.
      if (do_body) begin
         term = quote_single_ff ? CH_SQUOTE : CH_DQUOTE;
         if (c == term) begin
            add(bundle, mk_rec(KIND_FINISH, CLS_STRING, 8'h00, ERR_NONE));
            mode_in = MODE_IDLE;
         end else if (c == CH_NUL) begin
            fail(bundle, mode_in, ERR_UNTERM, c);
         end else if (count_in >= limit_ff) begin
            fail(bundle, mode_in, ERR_TOO_LONG, c);
         end else if (c == CH_BSLASH) begin
            mode_in = MODE_ESC;
         end else begin
            add(bundle, mk_rec(KIND_CHAR, CLS_STRING, c, ERR_NONE));
            count_in = count_in + 1'b1;
         end
      end

      // Between tokens, also reached when a byte ends a token and is scanned again.
      if (do_idle) begin
         mode_in = MODE_IDLE;
         if (c == CH_NUL) begin
            add(bundle, mk_rec(KIND_FINISH, CLS_EOT, 8'h00, ERR_NONE));
         end else if (is_space(c)) begin
            mode_in = MODE_IDLE;
         end else if (c == CH_SLASH) begin
            mode_in = MODE_SLASH;
         end else if (is_bracket(c)) begin
            add(bundle, mk_rec(KIND_CHAR, CLS_BRACKET, c, ERR_NONE));
            add(bundle, mk_rec(KIND_FINISH, CLS_BRACKET, c, ERR_NONE));
         end else if ((c == CH_DQUOTE) || (c == CH_SQUOTE)) begin
            quote_single_in = (c == CH_SQUOTE);
            count_in        = '0;
            mode_in         = MODE_STR;
         end else if (is_alpha(c)) begin
            count_in = '0;
            mode_in  = MODE_IDENT;
            append(bundle, mode_in, count_in, limit_ff, CLS_IDENT, c);
         end else if (is_digit(c) || (c == CH_MINUS)) begin
            count_in = '0;
            mode_in  = MODE_INT;
            append(bundle, mode_in, count_in, limit_ff, CLS_NUMBER, c);
         end else begin
            fail(bundle, mode_in, ERR_BAD_CHAR, c);
         end
      end
   end

   assign push_valid = accept && (bundle.count != '0);
   assign push_data  = bundle;

   // The limit in force is kept already clipped to the hard token limit.
   assign cfg_ext  = CMP_W'(csr_wdata);
   assign limit_in = (cfg_ext < CMP_W'(TOKEN_LIMIT)) ? CNT_W'(cfg_ext) : CNT_W'(TOKEN_LIMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff         <= MODE_IDLE;
         quote_single_ff <= 1'b0;
         count_ff        <= '0;
         esc_acc_ff      <= '0;
         limit_ff        <= CNT_W'(TOKEN_LIMIT);
      end else begin
         if (accept) begin
            mode_ff         <= mode_in;
            quote_single_ff <= quote_single_in;
            count_ff        <= count_in;
            esc_acc_ff      <= esc_acc_in;
         end
         if (csr_valid) begin
            limit_ff <= limit_in;
         end
      end
   end

endmodule

// ----- rtl/tts_queue.sv -----
module tts_queue import tts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       push_valid,
   output logic       push_ready,
   input  bundle_type push_data,
   output logic       pop_valid,
   input  logic       pop_ready,
   output bundle_type pop_data
);

   bundle_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CW-1:0]   fill_ff, fill_in;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (fill_ff != QUEUE_CW'(QUEUE_DEPTH));
   assign pop_valid  = (fill_ff != '0);
   assign pop_data   = entries_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? QUEUE_AW'((32'(wr_ptr_ff) + 1) % QUEUE_DEPTH) : wr_ptr_ff;
      rd_ptr_in = do_pop  ? QUEUE_AW'((32'(rd_ptr_ff) + 1) % QUEUE_DEPTH) : rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push && !do_pop) begin
         fill_in = fill_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- rtl/tts_back.sv -----
module tts_back import tts_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       pop_valid,
   output logic       pop_ready,
   input  bundle_type pop_data,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_rec_kind,
   output logic [2:0] rsp_token_class,
   output logic [7:0] rsp_value,
   output logic [1:0] rsp_err_code,
   output logic       rsp_last
);

   logic [REC_IDX_W-1:0] idx_ff, idx_in;
   logic                 valid_ff, valid_in;
   rec_type              rec_ff;
   logic                 last_ff;
   rec_type              cur;
   logic                 cur_last;
   logic                 load;

   assign load     = pop_valid && (!valid_ff || rsp_ready);
   assign cur      = pop_data.recs[idx_ff];
   assign cur_last = (REC_CNT_W'(idx_ff) == (pop_data.count - 1'b1));
   assign pop_ready = load && cur_last;

   always_comb begin
      idx_in   = idx_ff;
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
         idx_in   = cur_last ? '0 : idx_ff + 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rec_ff  <= cur;
         last_ff <= cur_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff   <= idx_in;
         valid_ff <= valid_in;
      end
   end

   assign rsp_valid       = valid_ff;
   assign rsp_rec_kind    = rec_ff.kind;
   assign rsp_token_class = rec_ff.cls;
   assign rsp_value       = rec_ff.value;
   assign rsp_err_code    = rec_ff.err;
   assign rsp_last        = last_ff;

endmodule

// ----- rtl/text_token_scanner_core.sv -----
// The first result of an accepted byte is written into the queue, then loaded into the output
// register that drives the result ports. Throughput: one byte per cycle while each byte gives
// at most one result and the result port is not stalled; a byte that gives more results holds
// the single output register until each is taken, and a four-entry queue of result groups
// between scanner and output absorbs such bursts.
// Reset (synchronous, active high) returns the scanner to idle between tokens, empties the
// queue and the output register and sets the length limit to its largest value.
module text_token_scanner_core import tts_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_ch,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic             rsp_rec_kind,
   output logic [2:0]       rsp_token_class,
   output logic [7:0]       rsp_value,
   output logic [1:0]       rsp_err_code,
   output logic             rsp_last,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [CFG_W-1:0] csr_wdata
);

   // The front scanner classifies each byte combinationally and produces every record that
   // the byte causes as one group. Groups with no records are not queued at all.
   logic       push_valid;
   logic       push_ready;
   bundle_type push_data;

   // The back end takes groups off the queue and hands their records out one at a time.
   logic       pop_valid;
   logic       pop_ready;
   bundle_type pop_data;

   // The limit register is written whenever the write port offers data, so it never needs to stall;
   // the user must change it only while no item is in flight, as the block does not enforce this.
   assign csr_ready = 1'b1;

   tts_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_ch     (req_ch),
      .csr_valid  (csr_valid),
      .csr_wdata  (csr_wdata),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tts_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   // The last flag marks the final record of each group, so it follows the byte
   // boundaries of the input exactly.
   tts_back u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (pop_valid),
      .pop_ready       (pop_ready),
      .pop_data        (pop_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_rec_kind    (rsp_rec_kind),
      .rsp_token_class (rsp_token_class),
      .rsp_value       (rsp_value),
      .rsp_err_code    (rsp_err_code),
      .rsp_last        (rsp_last)
   );

endmodule

// ----- rtl/tts_checker.sv -----
module tts_checker import tts_pkg::*; (
   input logic             clock,
   input logic             reset,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input logic             rsp_rec_kind,
   input logic [2:0]       rsp_token_class,
   input logic [7:0]       rsp_value,
   input logic [1:0]       rsp_err_code,
   input logic             rsp_last
);

   // A stalled result holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_rec_kind)
         && $stable(rsp_token_class) && $stable(rsp_value)
         && $stable(rsp_err_code) && $stable(rsp_last))
      else $error("result changed while stalled");

   // Token characters never carry an error code.
   a_char_no_err: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_rec_kind == KIND_CHAR) |-> (rsp_err_code == ERR_NONE))
      else $error("character record with error code");

   // An error is a finished record with a code and zero value, and ends its byte's results.
   a_err_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_token_class == CLS_ERROR) |->
         (rsp_rec_kind == KIND_FINISH) && (rsp_err_code != ERR_NONE)
         && (rsp_value == 8'h00) && rsp_last)
      else $error("malformed error record");

   // An error code appears only on the error class.
   a_err_class: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_err_code != ERR_NONE) |-> (rsp_token_class == CLS_ERROR))
      else $error("error code outside error class");

endmodule

bind text_token_scanner_core tts_checker u_checker (.*);
